FILE: rtl/core/markov_chain_state_sampler_unit_macros.svh
// Assertion macros used by the checker of the sampler.
`ifndef MARKOV_CHAIN_STATE_SAMPLER_UNIT_MACROS_SVH
`define MARKOV_CHAIN_STATE_SAMPLER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MCSS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sampler assertion failed");

// Check a property on every rising clock edge, reset included.
`define MCSS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("sampler assertion failed during reset");

`endif

FILE: rtl/core/mcss_pkg.sv
package mcss_pkg;

  localparam int MCSS_MAX_STATES = 16;
  localparam int MCSS_PROB_BITS  = 16;

  localparam int ROW_W   = 4;
  localparam int PROB_W  = 16;
  localparam int RND_W   = 16;
  localparam int STATE_W = 4;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] CFG_STATES_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_STEP     = 2'd0,
    OP_WR_TRANS = 2'd1,
    OP_WR_INIT  = 2'd2,
    OP_RESTART  = 2'd3
  } mcss_op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } mcss_fsm_e;

  typedef struct packed {
    logic trans_we;
    logic init_we;
  } mcss_wr_ctl_t;

  typedef struct packed {
    logic en;
    logic sel_init;
  } mcss_rd_ctl_t;

endpackage

FILE: rtl/core/mcss_if.sv
interface mcss_in_if;
  import mcss_pkg::*;

  logic              valid;
  logic              ready;
  mcss_op_e          op;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  col;
  logic [PROB_W-1:0] prob;
  logic [RND_W-1:0]  rnd;

  modport source (output valid, op, row, col, prob, rnd, input ready);
  modport sink   (input valid, op, row, col, prob, rnd, output ready);
endinterface

interface mcss_out_if;
  import mcss_pkg::*;

  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] next_state;
  logic               was_initial;

  modport source (output valid, next_state, was_initial, input ready);
  modport sink   (input valid, next_state, was_initial, output ready);
endinterface

interface mcss_cfg_if;
  import mcss_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] states_in_use;

  modport source (output valid, states_in_use, input ready);
  modport sink   (input valid, states_in_use, output ready);
endinterface

FILE: rtl/core/mcss_table.sv
module mcss_table #(
  parameter int MaxStates = mcss_pkg::MCSS_MAX_STATES,
  parameter int ProbBits  = mcss_pkg::MCSS_PROB_BITS,
  localparam int SW = (MaxStates > 1) ? $clog2(MaxStates) : 1
) (
  input  logic                  clk_i,
  input  mcss_pkg::mcss_wr_ctl_t wr_ctl_i,
  input  logic [SW-1:0]         wr_row_i,
  input  logic [SW-1:0]         wr_col_i,
  input  logic [ProbBits-1:0]   wr_data_i,
  input  mcss_pkg::mcss_rd_ctl_t rd_ctl_i,
  input  logic [SW-1:0]         rd_row_i,
  input  logic [SW-1:0]         rd_col_i,
  output logic [ProbBits-1:0]   rd_data_o
);
  import mcss_pkg::*;

  localparam int Depth = MaxStates * MaxStates;
  localparam int AW    = $clog2(Depth);

  logic [ProbBits-1:0] trans_mem [Depth];
  logic [ProbBits-1:0] init_mem  [MaxStates];

  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [ProbBits-1:0] trans_rdata_q;
  logic [ProbBits-1:0] init_rdata_q;
  logic                sel_init_q;

  assign wr_addr = AW'(wr_row_i) * AW'(MaxStates) + AW'(wr_col_i);
  assign rd_addr = AW'(rd_row_i) * AW'(MaxStates) + AW'(rd_col_i);

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.trans_we) begin
      trans_mem[wr_addr] <= wr_data_i;
    end
    if (wr_ctl_i.init_we) begin
      init_mem[wr_col_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_ctl_i.en) begin
      trans_rdata_q <= trans_mem[rd_addr];
      init_rdata_q  <= init_mem[rd_col_i];
      sel_init_q    <= rd_ctl_i.sel_init;
    end
  end

  assign rd_data_o = sel_init_q ? init_rdata_q : trans_rdata_q;

endmodule

FILE: rtl/core/mcss_scan.sv
module mcss_scan #(
  parameter int MaxStates = mcss_pkg::MCSS_MAX_STATES,
  parameter int ProbBits  = mcss_pkg::MCSS_PROB_BITS,
  localparam int SW = (MaxStates > 1) ? $clog2(MaxStates) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mcss_pkg::mcss_op_e            in_op_i,
  input  logic [mcss_pkg::ROW_W-1:0]    in_row_i,
  input  logic [mcss_pkg::ROW_W-1:0]    in_col_i,
  input  logic [mcss_pkg::PROB_W-1:0]   in_prob_i,
  input  logic [mcss_pkg::RND_W-1:0]    in_rnd_i,
  input  logic [mcss_pkg::CFG_W-1:0]    cfg_states_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mcss_pkg::STATE_W-1:0]  out_state_o,
  output logic                          out_initial_o,
  output mcss_pkg::mcss_wr_ctl_t        wr_ctl_o,
  output logic [SW-1:0]                 wr_row_o,
  output logic [SW-1:0]                 wr_col_o,
  output logic [ProbBits-1:0]           wr_data_o,
  output mcss_pkg::mcss_rd_ctl_t        rd_ctl_o,
  output logic [SW-1:0]                 rd_row_o,
  output logic [SW-1:0]                 rd_col_o,
  input  logic [ProbBits-1:0]           rd_data_i
);
  import mcss_pkg::*;

  localparam int CntW   = $clog2(MaxStates + 1);
  localparam int CfgCmW = (CntW > CFG_W) ? CntW : CFG_W;
  localparam int IdxCmW = (CntW > ROW_W) ? CntW : ROW_W;
  localparam int AccW   = ProbBits + SW + 1;
  localparam int RndCmW = (AccW > RND_W) ? AccW : RND_W;

  mcss_fsm_e          state_q, state_d;
  logic [SW-1:0]      cur_q, cur_d;
  logic               started_q, started_d;
  logic               init_q, init_d;
  logic [SW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [RND_W-1:0]   rnd_q, rnd_d;
  logic               out_valid_q, out_valid_d;
  logic [STATE_W-1:0] out_state_q, out_state_d;
  logic               out_init_q, out_init_d;

  logic            accept;
  logic            step_go;
  logic            row_ok;
  logic            col_ok;
  logic [CntW-1:0] count;
  logic [AccW-1:0] sum;
  logic            hit;
  logic            last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign step_go    = accept & (in_op_i == OP_STEP);

  assign row_ok = IdxCmW'(in_row_i) < IdxCmW'(MaxStates);
  assign col_ok = IdxCmW'(in_col_i) < IdxCmW'(MaxStates);

  // Clamp the row length to the table size.
  assign count = (CfgCmW'(cfg_states_i) > CfgCmW'(MaxStates)) ?
                 CntW'(MaxStates) : CntW'(cfg_states_i);

  assign wr_ctl_o.trans_we = accept & (in_op_i == OP_WR_TRANS) & row_ok & col_ok;
  assign wr_ctl_o.init_we  = accept & (in_op_i == OP_WR_INIT) & col_ok;
  assign wr_row_o          = SW'(in_row_i);
  assign wr_col_o          = SW'(in_col_i);
  assign wr_data_o         = ProbBits'(in_prob_i);

  assign sum  = acc_q + AccW'(rd_data_i);
  assign hit  = RndCmW'(sum) > RndCmW'(rnd_q);
  assign last = (CntW'(idx_q) + CntW'(1)) == cnt_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    started_d   = started_q;
    init_d      = init_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q;
    out_state_d = out_state_q;
    out_init_d  = out_init_q;
    rd_ctl_o    = '0;
    rd_row_o    = cur_q;
    rd_col_o    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && (in_op_i == OP_RESTART)) begin
          started_d = 1'b0;
        end
        if (step_go) begin
          init_d    = !started_q;
          started_d = 1'b1;
          idx_d     = '0;
          cnt_d     = count;
          acc_d     = '0;
          rnd_d     = in_rnd_i;
          if (count == '0) begin
            state_d = ST_DONE;
          end else begin
            // Fetch the first entry of the row.
            rd_ctl_o.en       = 1'b1;
            rd_ctl_o.sel_init = !started_q;
            state_d           = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          cur_d   = idx_q;
          state_d = ST_DONE;
        end else if (last) begin
          state_d = ST_DONE;
        end else begin
          // Advance to the next entry while the sum is still short.
          acc_d             = sum;
          idx_d             = idx_q + SW'(1);
          rd_ctl_o.en       = 1'b1;
          rd_ctl_o.sel_init = init_q;
          rd_col_o          = idx_q + SW'(1);
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_state_d = STATE_W'(cur_q);
          out_init_d  = init_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    init_q      <= init_d;
    idx_q       <= idx_d;
    cnt_q       <= cnt_d;
    acc_q       <= acc_d;
    rnd_q       <= rnd_d;
    out_state_q <= out_state_d;
    out_init_q  <= out_init_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_state_o   = out_state_q;
  assign out_initial_o = out_init_q;

endmodule

FILE: rtl/core/markov_chain_state_sampler_unit.sv
// Markov chain state sampler.
// in_ch_i carries one item a beat: op selects a step, a write of a
// transition entry (row, col, prob), a write of an initial entry (col, prob)
// or a restart. Writes and restarts give no result and keep in_ch_i ready.
// A step gives one beat on out_ch_o: the new state and whether it was drawn
// from the initial distribution. cfg_ch_i sets the number of states in use;
// it is always ready. The user must write it only while the block is idle;
// the block does not enforce this. A step walks the selected row through
// the table memory, one entry a cycle, each read being registered in the
// table: with N states in use it reads at most N entries, fewer when the
// pick comes early, and in_ch_i is not ready in between.
// The output beat sits in a register, so the next item is accepted while the
// result is still waiting; a step that finishes before the previous result
// is taken holds in its last state until out_ch_o frees up.
// Reset clears the current state to zero, the started flag and the output
// valid, and sets the states in use to sixteen. Table contents are not
// cleared and must be written before they are used.
module markov_chain_state_sampler_unit #(
  parameter int MaxStates = mcss_pkg::MCSS_MAX_STATES,
  parameter int ProbBits  = mcss_pkg::MCSS_PROB_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mcss_in_if.sink           in_ch_i,
  mcss_out_if.source        out_ch_o,
  mcss_cfg_if.sink          cfg_ch_i
);
  import mcss_pkg::*;

  localparam int SW = (MaxStates > 1) ? $clog2(MaxStates) : 1;

  logic [CFG_W-1:0]    states_q;
  mcss_wr_ctl_t        wr_ctl;
  logic [SW-1:0]       wr_row;
  logic [SW-1:0]       wr_col;
  logic [ProbBits-1:0] wr_data;
  mcss_rd_ctl_t        rd_ctl;
  logic [SW-1:0]       rd_row;
  logic [SW-1:0]       rd_col;
  logic [ProbBits-1:0] rd_data;

  assign cfg_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      states_q <= CFG_STATES_RESET;
    end else if (cfg_ch_i.valid) begin
      states_q <= cfg_ch_i.states_in_use;
    end
  end

  mcss_scan #(
    .MaxStates (MaxStates),
    .ProbBits  (ProbBits)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch_i.valid),
    .in_ready_o    (in_ch_i.ready),
    .in_op_i       (in_ch_i.op),
    .in_row_i      (in_ch_i.row),
    .in_col_i      (in_ch_i.col),
    .in_prob_i     (in_ch_i.prob),
    .in_rnd_i      (in_ch_i.rnd),
    .cfg_states_i  (states_q),
    .out_valid_o   (out_ch_o.valid),
    .out_ready_i   (out_ch_o.ready),
    .out_state_o   (out_ch_o.next_state),
    .out_initial_o (out_ch_o.was_initial),
    .wr_ctl_o      (wr_ctl),
    .wr_row_o      (wr_row),
    .wr_col_o      (wr_col),
    .wr_data_o     (wr_data),
    .rd_ctl_o      (rd_ctl),
    .rd_row_o      (rd_row),
    .rd_col_o      (rd_col),
    .rd_data_i     (rd_data)
  );

  mcss_table #(
    .MaxStates (MaxStates),
    .ProbBits  (ProbBits)
  ) u_table (
    .clk_i     (clk_i),
    .wr_ctl_i  (wr_ctl),
    .wr_row_i  (wr_row),
    .wr_col_i  (wr_col),
    .wr_data_i (wr_data),
    .rd_ctl_i  (rd_ctl),
    .rd_row_i  (rd_row),
    .rd_col_i  (rd_col),
    .rd_data_o (rd_data)
  );

endmodule

FILE: rtl/core/mcss_checker.sv
`include "markov_chain_state_sampler_unit_macros.svh"

module mcss_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input mcss_pkg::mcss_op_e           in_op_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [mcss_pkg::STATE_W-1:0] out_state_i,
  input logic                         out_initial_i
);
  import mcss_pkg::*;

  logic               in_acc;
  logic               load_acc;
  logic               out_stall;
  logic [STATE_W:0]   out_beat;
  assign in_acc    = in_valid_i & in_ready_i;
  assign load_acc  = in_acc & (in_op_i != OP_STEP);
  assign out_stall = out_valid_i & !out_ready_i;
  assign out_beat  = {out_state_i, out_initial_i};

  // A stalled result beat holds its value.
  `MCSS_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i && $stable(out_beat))

  // A step keeps the input closed while the row is walked.
  `MCSS_ASSERT(a_step_busy, clk_i, rst_ni, in_acc && (in_op_i == OP_STEP) |=> !in_ready_i)

  // A write or restart never raises a result.
  `MCSS_ASSERT(a_load_silent, clk_i, rst_ni, load_acc && !out_valid_i |=> !out_valid_i)

  // A reset held over an edge leaves no result pending.
  `MCSS_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni && $past(!rst_ni) |-> !out_valid_i)

endmodule

bind markov_chain_state_sampler_unit mcss_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch_i.valid),
  .in_ready_i    (in_ch_i.ready),
  .in_op_i       (in_ch_i.op),
  .out_valid_i   (out_ch_o.valid),
  .out_ready_i   (out_ch_o.ready),
  .out_state_i   (out_ch_o.next_state),
  .out_initial_i (out_ch_o.was_initial)
);

FILE: verif/markov_chain_state_sampler_unit_test.sv
`timescale 1ns / 100ps

module markov_chain_state_sampler_unit_test;
  import mcss_pkg::*;

  localparam int NumStates   = MCSS_MAX_STATES;
  localparam int DrainCycles = 40;
  localparam int TimeLimitNs = 5_000_000;

  typedef struct packed {
    mcss_op_e          op;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic [PROB_W-1:0] prob;
    logic [RND_W-1:0]  rnd;
  } chain_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic               was_initial;
  } draw_t;

  typedef struct packed {
    chain_item_t item;
    logic        typed;
    draw_t       draw;
  } dir_row_t;

  typedef struct {
    logic [CFG_W-1:0] states;
    int               src_idle;
    int               sink_stall;
    int               n_items;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mcss_in_if  in_ch ();
  mcss_out_if out_ch ();
  mcss_cfg_if cfg_ch ();

  markov_chain_state_sampler_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .cfg_ch_i (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // Chain predictor state, plus which table entries have been loaded.
  logic [PROB_W-1:0]  trans_prob [NumStates*NumStates];
  logic [PROB_W-1:0]  init_prob [NumStates];
  bit                 trans_known [NumStates*NumStates];
  bit                 init_known [NumStates];
  logic [STATE_W-1:0] chain_state;
  bit                 chain_started;
  logic [CFG_W-1:0]   states_in_use;

  draw_t pending_draws [$];
  int    n_errors = 0;
  int    src_idle_pct = 0;
  int    sink_stall_pct = 0;

  function automatic void reset_chain();
    foreach (trans_prob[i]) begin
      trans_prob[i]  = '0;
      trans_known[i] = 1'b0;
    end
    foreach (init_prob[i]) begin
      init_prob[i]  = '0;
      init_known[i] = 1'b0;
    end
    chain_state   = '0;
    chain_started = 1'b0;
    states_in_use = CFG_STATES_RESET;
  endfunction

  function automatic int scan_count();
    return (states_in_use > NumStates) ? NumStates : int'(states_in_use);
  endfunction

  // First column the next step would read that was never loaded, or -1.
  function automatic int first_unloaded_col();
    int n;
    n = scan_count();
    for (int c = 0; c < n; c++) begin
      if (!chain_started && !init_known[c]) return c;
      if (chain_started && !trans_known[int'(chain_state) * NumStates + c]) return c;
    end
    return -1;
  endfunction

  // Apply one accepted item; return 1 with the drawn state for a step.
  function automatic bit advance_chain(chain_item_t it, output draw_t d);
    int                n;
    int                pick;
    logic [PROB_W+4:0] acc;
    logic [PROB_W-1:0] p;
    d = '0;
    case (it.op)
      OP_WR_TRANS: begin
        trans_prob[int'(it.row) * NumStates + int'(it.col)]  = it.prob;
        trans_known[int'(it.row) * NumStates + int'(it.col)] = 1'b1;
        return 1'b0;
      end
      OP_WR_INIT: begin
        init_prob[it.col]  = it.prob;
        init_known[it.col] = 1'b1;
        return 1'b0;
      end
      OP_RESTART: begin
        chain_started = 1'b0;
        return 1'b0;
      end
      default: begin
        n    = scan_count();
        acc  = '0;
        pick = -1;
        for (int c = 0; c < n; c++) begin
          p = chain_started ? trans_prob[int'(chain_state) * NumStates + c] : init_prob[c];
          if (pick < 0) begin
            acc = acc + p;
            if (acc > it.rnd) pick = c;
          end
        end
        d.was_initial = !chain_started;
        if (pick >= 0) chain_state = pick[STATE_W-1:0];
        chain_started = 1'b1;
        d.next_state  = chain_state;
        return 1'b1;
      end
    endcase
  endfunction

  // Mostly spread a row near one in total, with zeros and full-scale values mixed in.
  function automatic logic [PROB_W-1:0] draw_prob();
    int n;
    int lim;
    n = (scan_count() == 0) ? 1 : scan_count();
    lim = 131072 / n - 1;
    if (lim > 65535) lim = 65535;
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return PROB_W'($urandom);
      default: return PROB_W'($urandom_range(lim));
    endcase
  endfunction

  function automatic logic [RND_W-1:0] draw_rnd();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return RND_W'($urandom);
    endcase
  endfunction

  function automatic chain_item_t next_random_item();
    chain_item_t it;
    int          roll;
    int          gap;
    it.row  = ROW_W'($urandom);
    it.col  = ROW_W'($urandom);
    it.prob = draw_prob();
    it.rnd  = draw_rnd();
    roll = $urandom_range(99);
    if (roll < 60)      it.op = OP_STEP;
    else if (roll < 80) it.op = OP_WR_TRANS;
    else if (roll < 92) it.op = OP_WR_INIT;
    else                it.op = OP_RESTART;
    // Load the row a step would scan before letting the step through.
    if (it.op == OP_STEP) begin
      gap = first_unloaded_col();
      if (gap >= 0) begin
        it.op  = chain_started ? OP_WR_TRANS : OP_WR_INIT;
        it.row = chain_state;
        it.col = gap[ROW_W-1:0];
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic send_item(chain_item_t it, bit typed, draw_t typed_draw);
    draw_t d;
    in_ch.valid <= 1'b1;
    in_ch.op    <= it.op;
    in_ch.row   <= it.row;
    in_ch.col   <= it.col;
    in_ch.prob  <= it.prob;
    in_ch.rnd   <= it.rnd;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (advance_chain(it, d)) pending_draws.push_back(typed ? typed_draw : d);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic write_states_in_use(logic [CFG_W-1:0] v);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.states_in_use <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    states_in_use = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    draw_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_draws.size() == 0) begin
        report_mismatch("unexpected beat, next_state", out_ch.next_state, -1);
      end else begin
        want = pending_draws.pop_front();
        if (out_ch.next_state !== want.next_state)
          report_mismatch("next_state", out_ch.next_state, want.next_state);
        if (out_ch.was_initial !== want.was_initial)
          report_mismatch("was_initial", out_ch.was_initial, want.was_initial);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    dir_row_t dir_tbl [23];
    phase_t   phases [8];
    draw_t    none;

    reset_chain();
    none = '0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_STEP;
    in_ch.row            = '0;
    in_ch.col            = '0;
    in_ch.prob           = '0;
    in_ch.rnd            = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.states_in_use = CFG_STATES_RESET;

    // Two states in use so the directed rows fit in a few loads.
    dir_tbl = '{
      '{'{OP_WR_INIT,  4'd0,  4'd0,  16'h0000, 16'h0000}, 1'b0, '0},
      '{'{OP_WR_INIT,  4'd0,  4'd1,  16'hFFFF, 16'h0000}, 1'b0, '0},
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{4'd1, 1'b1}},
      '{'{OP_WR_TRANS, 4'd1,  4'd0,  16'hFFFF, 16'h0000}, 1'b0, '0},
      '{'{OP_WR_TRANS, 4'd1,  4'd1,  16'h0000, 16'h0000}, 1'b0, '0},
      // running sum never exceeds full-scale rnd: hold the state
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'hFFFF}, 1'b1, '{4'd1, 1'b0}},
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'hFFFE}, 1'b1, '{4'd0, 1'b0}},
      '{'{OP_WR_TRANS, 4'd0,  4'd0,  16'd40000, 16'h0000}, 1'b0, '0},
      '{'{OP_WR_TRANS, 4'd0,  4'd1,  16'd40000, 16'h0000}, 1'b0, '0},
      // row sums past one: the last entry is picked
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'hFFFF}, 1'b1, '{4'd1, 1'b0}},
      '{'{OP_RESTART,  4'd0,  4'd0,  16'h0000, 16'h0000}, 1'b0, '0},
      // first step with no pick still reports an initial draw
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'hFFFF}, 1'b1, '{4'd1, 1'b1}},
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{4'd0, 1'b0}},
      '{'{OP_RESTART,  4'd0,  4'd0,  16'h0000, 16'h0000}, 1'b0, '0},
      '{'{OP_RESTART,  4'd15, 4'd15, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{OP_WR_INIT,  4'd15, 4'd0,  16'hFFFF, 16'h0000}, 1'b0, '0},
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'hFFFF}, 1'b1, '{4'd1, 1'b1}},
      '{'{OP_WR_TRANS, 4'd15, 4'd15, 16'h1234, 16'h0000}, 1'b0, '0},
      '{'{OP_WR_INIT,  4'd0,  4'd15, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'h8000}, 1'b1, '{4'd0, 1'b0}},
      '{'{OP_WR_TRANS, 4'd0,  4'd0,  16'h5A5A, 16'h0000}, 1'b0, '0},
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'hA5A5}, 1'b0, '0},
      '{'{OP_STEP,     4'd0,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{4'd0, 1'b0}}
    };

    phases = '{
      '{5'd16, 0,  0,  100},
      '{5'd1,  88, 0,  40},
      '{5'd4,  0,  88, 80},
      '{5'd16, 37, 37, 100},
      '{5'd0,  0,  0,  30},
      '{5'd31, 37, 37, 60},
      '{5'd8,  88, 0,  80},
      '{5'd3,  0,  0,  60}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_states_in_use(5'd2);
    foreach (dir_tbl[i]) send_item(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].draw);
    wait_idle();

    foreach (phases[p]) begin
      src_idle_pct   = phases[p].src_idle;
      sink_stall_pct = phases[p].sink_stall;
      write_states_in_use(phases[p].states);
      repeat (phases[p].n_items) send_item(next_random_item(), 1'b0, none);
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TimeLimitNs);
    $display("TEST FAILED");
    $finish;
  end

endmodule
